// ----- sv/tzam_pkg.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor package
// Shared types and constants for the monitor controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tzam_pkg;
   localparam int unsigned TempWidth  = 8;
   localparam int unsigned TickWidth  = 24;
   localparam int unsigned BlinkWidth = 10;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   localparam logic [CsrIndexWidth-1:0] CSR_LOW_LIMIT    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MID_POINT    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HIGH_LIMIT   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CRIT_LIMIT   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DWELL_TICKS  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_TICKS = 3'd5;

   localparam logic [1:0] ZONE_LOW    = 2'd0;
   localparam logic [1:0] ZONE_NORMAL = 2'd1;
   localparam logic [1:0] ZONE_HIGH   = 2'd2;
   localparam logic [1:0] ZONE_CRIT   = 2'd3;

   localparam logic [1:0] TONE_NONE   = 2'd0;
   localparam logic [1:0] TONE_LONG   = 2'd1;
   localparam logic [1:0] TONE_SHORT  = 2'd2;
   localparam logic [1:0] TONE_REPEAT = 2'd3;

   localparam logic [BlinkWidth-1:0] BlinkOffTicks = 10'd300;
   localparam logic [BlinkWidth-1:0] BlinkOnTicks  = 10'd1000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic div_start;
      logic commit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic div_done;
   } status_type;
endpackage
`default_nettype wire

// ----- sv/tzam_if.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor channel interfaces
// Valid/ready channels for the tick input and the status result.
// ----------------------------------------------------------------------------
`default_nettype none
interface tzam_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] temperature;
   logic       ack_click;
   modport source (output valid, temperature, ack_click, input ready);
   modport sink   (input valid, temperature, ack_click, output ready);
endinterface

interface tzam_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] zone_status;
   logic       alarm_active;
   logic [1:0] alarm_start_tone;
   logic       alarm_stop;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;
   logic       display_on;
   modport source (output valid, zone_status, alarm_active, alarm_start_tone,
                   alarm_stop, red_level, green_level, blue_level, display_on,
                   input ready);
   modport sink   (input valid, zone_status, alarm_active, alarm_start_tone,
                   alarm_stop, red_level, green_level, blue_level, display_on,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/tzam_div.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor divider
// Restoring divider, one quotient bit per cycle, 16-bit dividend, 8-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module tzam_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic             done,
   output logic [15:0]      quotient
);
   logic [15:0] quot_ff, quot_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  div_ff, div_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [9:0]  trial;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, quot_ff[15]} - {2'b00, div_ff};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = 5'd16;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[9]) begin
            rem_in = trial[8:0];
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[7:0], quot_ff[15]};
            quot_in = {quot_ff[14:0], 1'b0};
         end
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = !busy_ff && !start;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ----- sv/tzam_ctrl.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor controller
// Sequences accept, interpolation divide and result handoff for each tick.
// ----------------------------------------------------------------------------
`default_nettype none
module tzam_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire tzam_pkg::status_type status,
   output tzam_pkg::cmd_type         cmd
);
   tzam_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tzam_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      req_ready     = 1'b0;
      unique case (state_ff)
         tzam_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = tzam_pkg::ST_DIVIDE;
            end
         end
         tzam_pkg::ST_DIVIDE: begin
            cmd.div_start = 1'b1;
            state_in      = tzam_pkg::ST_RESULT;
         end
         tzam_pkg::ST_RESULT: begin
            // Commit once the divide is done and the output register is free.
            if (status.div_done && (!out_valid_ff || rsp_ready)) begin
               cmd.commit   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = tzam_pkg::ST_IDLE;
            end
         end
         default: state_in = tzam_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;
endmodule
`default_nettype wire

// ----- sv/tzam_dp.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor datapath
// Zone timers, alarm flags, blink timer, LED interpolation and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module tzam_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tzam_pkg::cmd_type cmd,
   output tzam_pkg::status_type   status,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_write_data,
   input  wire logic [7:0]        in_temperature,
   input  wire logic              in_ack_click,
   output logic [1:0]             out_zone_status,
   output logic                   out_alarm_active,
   output logic [1:0]             out_alarm_start_tone,
   output logic                   out_alarm_stop,
   output logic [7:0]             out_red_level,
   output logic [7:0]             out_green_level,
   output logic [7:0]             out_blue_level,
   output logic                   out_display_on
);
   localparam logic [23:0] Max24 = 24'hFFFFFF;
   localparam logic [9:0]  Max10 = 10'h3FF;

   logic [7:0]  low_ff, mid_ff, high_ff, crit_ff;
   logic [23:0] dwell_ff, repeat_ticks_ff;

   logic [7:0]  temp_ff;
   logic        click_ff;

   logic        ack_pending_ff, ack_pending_in;
   logic [3:0]  started_ff, started_in;
   logic [23:0] elapsed_ff [4];
   logic [23:0] elapsed_in [4];
   logic        alarm_on_ff, alarm_on_in;
   logic        high_armed_ff, high_armed_in;
   logic        crit_armed_ff, crit_armed_in;
   logic        repeat_armed_ff, repeat_armed_in;
   logic [23:0] repeat_elapsed_ff, repeat_elapsed_in;
   logic        blink_phase_ff, blink_phase_in;
   logic [9:0]  blink_elapsed_ff, blink_elapsed_in;
   logic [7:0]  led_ff [3];
   logic [7:0]  led_in [3];
   logic        display_ff, display_in;
   logic [1:0]  last_zone_ff, last_zone_in;

   logic [1:0]  zone_out_ff;
   logic        alarm_out_ff;
   logic [1:0]  tone_out_ff;
   logic        stop_out_ff;
   logic [7:0]  red_out_ff, green_out_ff, blue_out_ff;
   logic        display_out_ff;

   // Interpolation operands, set up at accept time.
   logic [15:0] num_a_ff, num_a_in;
   logic [7:0]  span_ff, span_in;
   logic [2:0]  led_mode_ff, led_mode_in;
   logic [15:0] quotient;
   logic        div_done;

   localparam logic [2:0] LED_HOLD   = 3'd0;
   localparam logic [2:0] LED_OFF    = 3'd1;
   localparam logic [2:0] LED_COOL   = 3'd2;
   localparam logic [2:0] LED_MID    = 3'd3;
   localparam logic [2:0] LED_WARM   = 3'd4;
   localparam logic [2:0] LED_HIGHPT = 3'd5;
   localparam logic [2:0] LED_HOT    = 3'd6;

   tzam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_a_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quotient)
   );
   assign status.div_done = div_done;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff          <= 8'd25;
         mid_ff          <= 8'd35;
         high_ff         <= 8'd55;
         crit_ff         <= 8'd70;
         dwell_ff        <= 24'd60000;
         repeat_ticks_ff <= 24'd300000;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tzam_pkg::CSR_LOW_LIMIT:    low_ff          <= csr_write_data[7:0];
            tzam_pkg::CSR_MID_POINT:    mid_ff          <= csr_write_data[7:0];
            tzam_pkg::CSR_HIGH_LIMIT:   high_ff         <= csr_write_data[7:0];
            tzam_pkg::CSR_CRIT_LIMIT:   crit_ff         <= csr_write_data[7:0];
            tzam_pkg::CSR_DWELL_TICKS:  dwell_ff        <= csr_write_data;
            tzam_pkg::CSR_REPEAT_TICKS: repeat_ticks_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Divide setup: the divide gives (d*k)/span; k chosen per mode.
   logic [7:0] d_cool, d_warm, d_hot;
   always_comb begin
      d_cool = in_temperature - low_ff;
      d_warm = in_temperature - mid_ff;
      d_hot  = in_temperature - high_ff;
      num_a_in    = '0;
      span_in     = 8'd1;
      led_mode_in = LED_HOLD;
      priority if (in_temperature >= crit_ff) begin
         led_mode_in = LED_HOLD;
      end else if (in_temperature < low_ff) begin
         led_mode_in = LED_OFF;
      end else if (in_temperature < mid_ff) begin
         led_mode_in = LED_COOL;
         num_a_in    = 16'(d_cool) * 16'd10;
         span_in     = mid_ff - low_ff;
      end else if (in_temperature == mid_ff) begin
         led_mode_in = LED_MID;
      end else if (in_temperature < high_ff) begin
         led_mode_in = LED_WARM;
         num_a_in    = 16'(d_warm) * 16'd10;
         span_in     = high_ff - mid_ff;
      end else if (in_temperature == high_ff) begin
         led_mode_in = LED_HIGHPT;
      end else begin
         led_mode_in = LED_HOT;
         num_a_in    = 16'(d_hot) * 16'd90;
         span_in     = crit_ff - high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         temp_ff     <= in_temperature;
         click_ff    <= in_ack_click;
         num_a_ff    <= num_a_in;
         span_ff     <= span_in;
         led_mode_ff <= led_mode_in;
      end
   end

   // (d*20)/s = 2*(d*10)/s + ((2*((d*10)%s)) >= s), so one divide serves both
   // colors; the remainder is recomputed from the quotient here.
   logic [15:0] rem10;
   logic [16:0] twice_rem;
   logic [15:0] q20;
   always_comb begin
      rem10     = num_a_ff - 16'(quotient * 16'(span_ff));
      twice_rem = {rem10, 1'b0};
      q20       = {quotient[14:0], 1'b0} + 16'(twice_rem >= 17'(span_ff));
   end

   // Tick state update.
   logic        valid_t;
   logic        in_low, in_norm, in_high, in_crit;
   logic [3:0]  in_zone;
   logic [3:0]  qual;
   logic        sel_ack, sel_lown, sel_high, sel_crit;
   logic [1:0]  tone;
   logic        stop;
   logic [23:0] el_inc [4];
   logic        bp_tmp;
   always_comb begin
      valid_t = (temp_ff != 8'd0) && (temp_ff <= 8'd200);
      in_low  = temp_ff <= low_ff;
      in_norm = (temp_ff > low_ff) && (temp_ff < high_ff);
      in_high = (temp_ff >= high_ff) && (temp_ff < crit_ff);
      in_crit = temp_ff >= crit_ff;
      in_zone = {in_crit, in_high, in_norm, in_low};

      ack_pending_in    = ack_pending_ff;
      started_in        = started_ff;
      alarm_on_in       = alarm_on_ff;
      high_armed_in     = high_armed_ff;
      crit_armed_in     = crit_armed_ff;
      repeat_armed_in   = repeat_armed_ff;
      repeat_elapsed_in = repeat_elapsed_ff;
      blink_phase_in    = blink_phase_ff;
      blink_elapsed_in  = blink_elapsed_ff;
      display_in        = display_ff;
      last_zone_in      = last_zone_ff;
      tone              = tzam_pkg::TONE_NONE;
      stop              = 1'b0;
      qual              = '0;
      sel_ack = 1'b0; sel_lown = 1'b0; sel_high = 1'b0; sel_crit = 1'b0;
      bp_tmp  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         el_inc[i]     = (started_ff[i] && elapsed_ff[i] != Max24) ?
                         elapsed_ff[i] + 24'd1 : elapsed_ff[i];
         elapsed_in[i] = elapsed_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         led_in[i] = led_ff[i];
      end

      if (valid_t) begin
         for (int i = 0; i < 4; i++) begin
            elapsed_in[i] = el_inc[i];
            qual[i] = in_zone[i] && started_ff[i] && (el_inc[i] >= dwell_ff);
         end
         if (repeat_elapsed_ff != Max24) repeat_elapsed_in = repeat_elapsed_ff + 24'd1;
         if (blink_elapsed_ff != Max10) blink_elapsed_in = blink_elapsed_ff + 10'd1;
         ack_pending_in = ack_pending_ff || click_ff;

         unique case (led_mode_ff)
            LED_HOLD: ;
            LED_OFF: begin
               led_in[0] = 8'd0; led_in[1] = 8'd0; led_in[2] = 8'd0;
            end
            LED_COOL: begin
               led_in[0] = 8'd0;
               led_in[1] = q20[7:0];
               led_in[2] = 8'd10 - quotient[7:0];
            end
            LED_MID: begin
               led_in[0] = 8'd0; led_in[1] = 8'd20; led_in[2] = 8'd0;
            end
            LED_WARM: begin
               led_in[0] = quotient[7:0];
               led_in[1] = 8'd20 - q20[7:0];
               led_in[2] = 8'd0;
            end
            LED_HIGHPT: begin
               led_in[0] = 8'd10; led_in[1] = 8'd0; led_in[2] = 8'd0;
            end
            LED_HOT: begin
               led_in[0] = 8'd10 + quotient[7:0];
               led_in[1] = 8'd0; led_in[2] = 8'd0;
            end
            default: ;
         endcase

         // Zone checks only happen for zones the alarm chain reaches. With
         // misordered limits several zones can hold the reading at once, so
         // the chain is decided by which zone qualifies first.
         priority if (alarm_on_ff && ack_pending_in) begin
            sel_ack = 1'b1;
         end else if (qual[0] || qual[1]) begin
            sel_lown = 1'b1;
         end else if (qual[2]) begin
            sel_high = 1'b1;
         end else if (qual[3]) begin
            sel_crit = 1'b1;
         end else begin
            sel_crit = 1'b0;
         end

         // Started flags: ack updates crit only, else checks run in order until a match.
         if (sel_ack) begin
            started_in[3] = in_crit;
            if (in_crit && !started_ff[3]) elapsed_in[3] = '0;
         end else begin
            for (int i = 0; i < 4; i++) begin
               if (i == 0 || !(qual[0] || (i > 1 && qual[1]) || (i > 2 && qual[2]))) begin
                  started_in[i] = in_zone[i];
                  if (in_zone[i] && !started_ff[i]) elapsed_in[i] = '0;
               end
            end
         end

         if (sel_ack) begin
            ack_pending_in = 1'b0;
            alarm_on_in    = 1'b0;
            stop           = 1'b1;
            if (qual[3]) begin
               repeat_armed_in   = 1'b1;
               repeat_elapsed_in = '0;
               last_zone_in      = tzam_pkg::ZONE_CRIT;
            end
         end else if (sel_lown) begin
            last_zone_in = qual[0] ? tzam_pkg::ZONE_LOW : tzam_pkg::ZONE_NORMAL;
            if (alarm_on_ff) begin
               alarm_on_in = 1'b0;
               stop        = 1'b1;
            end
            high_armed_in   = 1'b1;
            crit_armed_in   = 1'b1;
            repeat_armed_in = 1'b0;
         end else if (sel_high) begin
            last_zone_in = tzam_pkg::ZONE_HIGH;
            if (high_armed_ff && !alarm_on_ff) begin
               alarm_on_in   = 1'b1;
               high_armed_in = 1'b0;
               tone          = tzam_pkg::TONE_LONG;
            end
            crit_armed_in   = 1'b1;
            repeat_armed_in = 1'b0;
            display_in      = 1'b1;
         end else if (sel_crit) begin
            last_zone_in = tzam_pkg::ZONE_CRIT;
            if (repeat_armed_ff && repeat_elapsed_in >= repeat_ticks_ff) begin
               repeat_armed_in = 1'b0;
               alarm_on_in     = 1'b1;
               tone            = tzam_pkg::TONE_REPEAT;
            end else if (crit_armed_ff && !alarm_on_ff) begin
               alarm_on_in   = 1'b1;
               crit_armed_in = 1'b0;
               tone          = tzam_pkg::TONE_SHORT;
            end
            bp_tmp = blink_phase_ff;
            if (!blink_phase_ff && blink_elapsed_in >= tzam_pkg::BlinkOffTicks) begin
               bp_tmp = 1'b1; blink_elapsed_in = '0; display_in = 1'b1;
            end else if (blink_phase_ff && blink_elapsed_in >= tzam_pkg::BlinkOnTicks) begin
               bp_tmp = 1'b0; blink_elapsed_in = '0; display_in = 1'b0;
            end
            blink_phase_in = bp_tmp;
            led_in[0] = bp_tmp ? 8'd255 : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_pending_ff    <= 1'b0;
         started_ff        <= '0;
         alarm_on_ff       <= 1'b0;
         high_armed_ff     <= 1'b0;
         crit_armed_ff     <= 1'b0;
         repeat_armed_ff   <= 1'b0;
         repeat_elapsed_ff <= '0;
         blink_phase_ff    <= 1'b0;
         blink_elapsed_ff  <= '0;
         display_ff        <= 1'b1;
         last_zone_ff      <= tzam_pkg::ZONE_LOW;
         for (int i = 0; i < 4; i++) elapsed_ff[i] <= '0;
         for (int i = 0; i < 3; i++) led_ff[i] <= '0;
      end else if (cmd.commit) begin
         ack_pending_ff    <= ack_pending_in;
         started_ff        <= started_in;
         alarm_on_ff       <= alarm_on_in;
         high_armed_ff     <= high_armed_in;
         crit_armed_ff     <= crit_armed_in;
         repeat_armed_ff   <= repeat_armed_in;
         repeat_elapsed_ff <= repeat_elapsed_in;
         blink_phase_ff    <= blink_phase_in;
         blink_elapsed_ff  <= blink_elapsed_in;
         display_ff        <= display_in;
         last_zone_ff      <= last_zone_in;
         for (int i = 0; i < 4; i++) elapsed_ff[i] <= elapsed_in[i];
         for (int i = 0; i < 3; i++) led_ff[i] <= led_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         zone_out_ff    <= last_zone_in;
         alarm_out_ff   <= alarm_on_in;
         tone_out_ff    <= tone;
         stop_out_ff    <= stop;
         red_out_ff     <= led_in[0];
         green_out_ff   <= led_in[1];
         blue_out_ff    <= led_in[2];
         display_out_ff <= display_in;
      end
   end

   assign out_zone_status      = zone_out_ff;
   assign out_alarm_active     = alarm_out_ff;
   assign out_alarm_start_tone = tone_out_ff;
   assign out_alarm_stop       = stop_out_ff;
   assign out_red_level        = red_out_ff;
   assign out_green_level      = green_out_ff;
   assign out_blue_level       = blue_out_ff;
   assign out_display_on       = display_out_ff;
endmodule
`default_nettype wire

// ----- sv/temperature_zone_alarm_monitor.sv -----
// ----------------------------------------------------------------------------
// Temperature zone alarm monitor
// Per-tick zone qualification, alarm sequencing and RGB LED level generation.
// ----------------------------------------------------------------------------
// Each request transaction is one millisecond tick carrying a temperature
// reading and an acknowledge click; exactly one response transaction follows
// it. After acceptance a tick passes through the divide-start state, then the
// LED interpolation divider, which produces one quotient bit per cycle over a
// 16-bit dividend, and then the commit, which registers the response. The
// next request can be accepted in the cycle after the commit. Ticks are
// processed one at a time; a new request is taken while the previous
// response still waits in its output register. Configuration registers are
// written through the csr port; the user must write them only while the
// block is idle, as the block does not enforce this. They take effect on the
// next tick. Readings of 0 or above 200 leave all tick state untouched.
`default_nettype none
module temperature_zone_alarm_monitor (
   input  wire logic        clock,
   input  wire logic        reset,
   tzam_req_if.sink         req,
   tzam_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_write_data
);
   tzam_pkg::cmd_type    cmd;
   tzam_pkg::status_type status;

   // The controller owns the handshakes; the datapath holds all tick state.
   tzam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tzam_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .in_temperature       (req.temperature),
      .in_ack_click         (req.ack_click),
      .out_zone_status      (rsp.zone_status),
      .out_alarm_active     (rsp.alarm_active),
      .out_alarm_start_tone (rsp.alarm_start_tone),
      .out_alarm_stop       (rsp.alarm_stop),
      .out_red_level        (rsp.red_level),
      .out_green_level      (rsp.green_level),
      .out_blue_level       (rsp.blue_level),
      .out_display_on       (rsp.display_on)
   );
endmodule
`default_nettype wire
